/* rtl/core/lsn_pkg.sv */
package lsn_pkg;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_INPUT  = 2'd1;
  localparam logic [1:0] KIND_STEP   = 2'd2;

  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_RESET_POT  = 3'd1;
  localparam logic [2:0] REG_MEM_GAIN   = 3'd2;
  localparam logic [2:0] REG_CUR_DECAY  = 3'd3;
  localparam logic [2:0] REG_REFRACTORY = 3'd4;
  localparam logic [2:0] REG_STIM_GAIN  = 3'd5;

  localparam int QUEUE_SLOT = 1;
  localparam int MASK_BITS  = 17;

  // rate averaging: 0.95 / 0.05 on a spike, 0.99 otherwise
  localparam logic [31:0] RATE_UP_MUL = 32'd62259;
  localparam logic [32:0] RATE_UP_ADD = 33'd214794240;
  localparam logic [31:0] RATE_DN_MUL = 32'd64881;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE, S_XRD, S_XWR, S_NRD, S_NC1, S_NC2, S_NWR, S_SRD, S_SWR, S_OUT
  } state_t;

  typedef struct packed {
    logic [30:0]        threshold;
    logic signed [31:0] reset_pot;
    logic [30:0]        mem_gain;
    logic [15:0]        cur_decay;
    logic [7:0]         refr_steps;
    logic [30:0]        stim_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic signed [31:0] i;
    logic [7:0]         refr;
    logic [15:0]        rate;
  } nstate_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > SAT_MAX) return 32'sh7FFFFFFF;
    else if (x < SAT_MIN) return 32'sh80000000;
    else return signed'(x[31:0]);
  endfunction

endpackage

/* rtl/core/lsn_cfg_regs.sv */
module lsn_cfg_regs
  import lsn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold  <= 31'd65536;
      cfg_r.reset_pot  <= 32'sd0;
      cfg_r.mem_gain   <= 31'd655360;
      cfg_r.cur_decay  <= 16'd0;
      cfg_r.refr_steps <= 8'd1;
      cfg_r.stim_gain  <= 31'd655360;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD:  cfg_r.threshold  <= cfg_pwdata[30:0];
        REG_RESET_POT:  cfg_r.reset_pot  <= signed'(cfg_pwdata);
        REG_MEM_GAIN:   cfg_r.mem_gain   <= cfg_pwdata[30:0];
        REG_CUR_DECAY:  cfg_r.cur_decay  <= cfg_pwdata[15:0];
        REG_REFRACTORY: cfg_r.refr_steps <= cfg_pwdata[7:0];
        REG_STIM_GAIN:  cfg_r.stim_gain  <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD:  cfg_prdata = {1'b0, cfg_r.threshold};
      REG_RESET_POT:  cfg_prdata = cfg_r.reset_pot;
      REG_MEM_GAIN:   cfg_prdata = {1'b0, cfg_r.mem_gain};
      REG_CUR_DECAY:  cfg_prdata = {16'd0, cfg_r.cur_decay};
      REG_REFRACTORY: cfg_prdata = {24'd0, cfg_r.refr_steps};
      REG_STIM_GAIN:  cfg_prdata = {1'b0, cfg_r.stim_gain};
      default:        cfg_prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/lsn_state_mem.sv */
module lsn_state_mem #(
  parameter int DEPTH = 17,
  parameter int WIDTH = 184
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rd_ok_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (we) valid_r[waddr] <= 1'b1;
      rd_ok_r <= valid_r[raddr];
    end
  end

  assign rdata = rd_ok_r ? rdata_r : '0;

endmodule

/* rtl/core/lsn_weight_mem.sv */
module lsn_weight_mem #(
  parameter int DEPTH = 70
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [31:0]              rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lif_spiking_network_step.sv */
// Leaky integrate-and-fire network, one time step per STEP item.
// Input stream: in_tuser carries the item kind (load weight, add external
// input, run step); in_tdata the synapse or channel number and a Q16.16 value.
// Only a STEP item yields a transfer on the output stream: spike mask,
// predicted class and the two class rates.
// Configuration sits on an APB port, pready always high; write only while idle.
// Flow: in_tready is high only while the sequencer is idle. A weight load is
// written from the idle state; an external input passes a read and a write
// state. A time step first walks every neuron through the state memory (read,
// compute, write back), then visits each source neuron: a source that stayed
// silent last step is passed over with its whole fan-out at once, while each
// synapse of a source that spiked takes a weight and queue row read, then a
// write back; last the output register is loaded, and in_tready returns with
// out_tvalid. The weight and state memories each have one read port, which
// sets this sequence.
// Reset clears all neuron state and the delay queues (valid bits per row) and
// restores the register defaults; weights must be loaded before a step.
// If the receiver stalls, the result waits in the output register; further
// loads and inputs are still taken, and the next step's result waits for it.
module lif_spiking_network_step
  import lsn_pkg::*;
#(
  parameter int INPUT_NEURONS  = 5,
  parameter int HIDDEN_NEURONS = 10,
  parameter int OUTPUT_NEURONS = 2,
  parameter int DELAY_DEPTH    = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // target_index[6:0], data_value[38:7], zero pad
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // spike_mask[16:0], predicted_class[17],
                                  // class0_rate[33:18], class1_rate[49:34], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NEURONS  = INPUT_NEURONS + HIDDEN_NEURONS + OUTPUT_NEURONS;
  localparam int SOURCES  = INPUT_NEURONS + HIDDEN_NEURONS;
  localparam int OUT_BASE = SOURCES;
  localparam int SYN      = INPUT_NEURONS * HIDDEN_NEURONS + HIDDEN_NEURONS * OUTPUT_NEURONS;
  localparam int NA_W     = $clog2(NEURONS);
  localparam int SA_W     = $clog2(SYN);
  localparam int SRC_W    = $clog2(SOURCES);
  localparam int FAN_MAX  = (HIDDEN_NEURONS > OUTPUT_NEURONS) ? HIDDEN_NEURONS : OUTPUT_NEURONS;
  localparam int J_W      = (FAN_MAX > 1) ? $clog2(FAN_MAX) : 1;
  localparam int OC_W     = $clog2(OUTPUT_NEURONS);
  localparam int NS_W     = $bits(nstate_t);
  localparam int ROW_W    = NS_W + DELAY_DEPTH * 32;

  typedef logic [DELAY_DEPTH-1:0][31:0] queue_t;

  cfg_t cfg;

  lsn_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  // memory ports
  logic             st_we;
  logic [NA_W-1:0]  st_waddr, st_raddr;
  logic [ROW_W-1:0] st_wdata, st_rdata;
  logic             w_we;
  logic [SA_W-1:0]  w_waddr;
  logic [31:0]      w_rdata;
  logic [SA_W-1:0]  s_r;

  lsn_state_mem #(.DEPTH(NEURONS), .WIDTH(ROW_W)) u_state (
    .clk, .rst_n, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  lsn_weight_mem #(.DEPTH(SYN)) u_weight (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(in_tdata[38:7]),
    .raddr(s_r), .rdata(w_rdata)
  );

  state_t st_r, st_nxt;

  logic               in_acc;
  logic [1:0]         kind;
  logic [6:0]         in_idx;
  logic [6:0]         idx_r;
  logic signed [31:0] data_r;

  logic [NA_W-1:0]    n_r;
  logic [SRC_W-1:0]   src_r;
  logic [J_W-1:0]     j_r;
  logic [NEURONS-1:0] spk_r;
  logic [SOURCES-1:0] prev_r;
  logic [OC_W-1:0]    best_r;
  logic [15:0]        best_rate_r, rate0_r, rate1_r;

  // neuron walk pipeline
  logic signed [31:0] cur_r, v_r;
  logic signed [32:0] diff_r;
  logic [7:0]         refr_r;
  logic [15:0]        rate_r;
  queue_t             qsh_r;
  logic signed [64:0] prod_v_r;
  logic signed [48:0] prod_i_r;
  logic [31:0]        prod_up_r, prod_dn_r;
  logic signed [63:0] xprod_r;

  logic               out_tvalid_r;
  logic [55:0]        out_tdata_r;

  nstate_t            rd_ns;
  queue_t             rd_q;
  logic               is_in_src, last_j, last_src, last_n;
  logic [NA_W-1:0]    tgt;
  logic [SA_W-1:0]    fanout;

  // neuron write-back values
  nstate_t            nwr_ns;
  logic               nwr_spike;

  assign in_acc = in_tvalid & in_tready;
  assign kind   = in_tuser;
  assign in_idx = in_tdata[6:0];
  assign rd_ns  = nstate_t'(st_rdata[NS_W-1:0]);
  assign rd_q   = queue_t'(st_rdata[ROW_W-1:NS_W]);

  assign is_in_src = (32'(src_r) < INPUT_NEURONS);
  assign fanout    = is_in_src ? SA_W'(HIDDEN_NEURONS) : SA_W'(OUTPUT_NEURONS);
  assign last_j    = is_in_src ? (32'(j_r) == HIDDEN_NEURONS - 1)
                               : (32'(j_r) == OUTPUT_NEURONS - 1);
  assign last_src  = (32'(src_r) == SOURCES - 1);
  assign last_n    = (32'(n_r) == NEURONS - 1);
  assign tgt       = is_in_src ? NA_W'(32'(INPUT_NEURONS) + 32'(j_r))
                               : NA_W'(32'(OUT_BASE) + 32'(j_r));

  assign w_we    = in_acc && (kind == KIND_WEIGHT) && (32'(in_idx) < SYN);
  assign w_waddr = SA_W'(in_idx);

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end

  // next state and memory port control
  always_comb begin
    st_nxt   = st_r;
    st_raddr = n_r;
    st_waddr = n_r;
    st_we    = 1'b0;
    st_wdata = '0;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          case (kind)
            KIND_INPUT: if (32'(in_idx) < INPUT_NEURONS) st_nxt = S_XRD;
            KIND_STEP:  st_nxt = S_NRD;
            default: ;
          endcase
        end
      end
      S_XRD: begin
        st_raddr = NA_W'(idx_r);
        st_nxt   = S_XWR;
      end
      S_XWR: begin
        nstate_t ns;
        ns       = rd_ns;
        ns.i     = sat32(64'(ns.i) + 64'(sat32(64'(xprod_r >>> 16))));
        st_waddr = NA_W'(idx_r);
        st_we    = 1'b1;
        st_wdata = {rd_q, ns};
        st_nxt   = S_IDLE;
      end
      S_NRD: st_nxt = S_NC1;
      S_NC1: st_nxt = S_NC2;
      S_NC2: st_nxt = S_NWR;
      S_NWR: begin
        st_we    = 1'b1;
        st_wdata = {qsh_r, nwr_ns};
        st_nxt   = last_n ? S_SRD : S_NRD;
      end
      S_SRD: begin
        st_raddr = tgt;
        if (prev_r[src_r]) st_nxt = S_SWR;
        else if (last_src) st_nxt = S_OUT;
      end
      S_SWR: begin
        queue_t q;
        q             = rd_q;
        q[QUEUE_SLOT] = sat32(64'(signed'(q[QUEUE_SLOT])) + 64'(signed'(w_rdata)));
        st_waddr      = tgt;
        st_we         = 1'b1;
        st_wdata      = {q, rd_ns};
        st_nxt        = (last_j && last_src) ? S_OUT : S_SRD;
      end
      S_OUT: if (!out_tvalid_r || out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    logic signed [31:0] vn;
    logic [16:0]        up;
    nwr_ns    = '0;
    nwr_spike = 1'b0;
    vn        = sat32(64'(v_r) + 64'(prod_v_r >>> 16));
    up        = 17'((33'(prod_up_r) + RATE_UP_ADD) >> 16);
    if (refr_r != 8'd0) begin
      nwr_ns.v    = cfg.reset_pot;
      nwr_ns.i    = cur_r;
      nwr_ns.refr = refr_r - 8'd1;
      nwr_ns.rate = rate_r;
    end else begin
      nwr_ns.i = sat32(64'(prod_i_r >>> 16));
      if (vn >= signed'({1'b0, cfg.threshold})) begin
        nwr_spike   = 1'b1;
        nwr_ns.v    = cfg.reset_pot;
        nwr_ns.refr = cfg.refr_steps;
        nwr_ns.rate = up[16] ? 16'hFFFF : up[15:0];
      end else begin
        nwr_ns.v    = vn;
        nwr_ns.refr = 8'd0;
        nwr_ns.rate = prod_dn_r[31:16];
      end
    end
  end

  // control counters and step bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spk_r        <= '0;
      prev_r       <= '0;
      n_r          <= '0;
      src_r        <= '0;
      j_r          <= '0;
      s_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (st_r == S_OUT && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready)               out_tvalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_acc && kind == KIND_STEP) begin
            prev_r <= spk_r[SOURCES-1:0];
            spk_r  <= '0;
            n_r    <= '0;
            src_r  <= '0;
            j_r    <= '0;
            s_r    <= '0;
          end
        end
        S_NWR: begin
          spk_r[n_r] <= nwr_spike;
          n_r        <= last_n ? '0 : n_r + 1'b1;
        end
        S_SRD: begin
          // skip the whole fan-out of a silent source
          if (!prev_r[src_r]) begin
            s_r   <= s_r + fanout;
            src_r <= src_r + 1'b1;
          end
        end
        S_SWR: begin
          s_r <= s_r + 1'b1;
          if (last_j) begin
            j_r   <= '0;
            src_r <= src_r + 1'b1;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  logic [MASK_BITS-1:0] mask;
  for (genvar k = 0; k < MASK_BITS; k++) begin : g_mask
    if (k < NEURONS) begin : g_on
      assign mask[k] = spk_r[k];
    end else begin : g_off
      assign mask[k] = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_r  <= in_idx;
          data_r <= signed'(in_tdata[38:7]);
        end
      end
      S_XRD: xprod_r <= 64'(signed'({1'b0, cfg.stim_gain})) * 64'(data_r);
      S_NC1: begin
        logic signed [31:0] cur;
        cur    = sat32(64'(rd_ns.i) + 64'(signed'(rd_q[0])));
        cur_r  <= cur;
        v_r    <= rd_ns.v;
        diff_r <= 33'(cur) - 33'(rd_ns.v);
        refr_r <= rd_ns.refr;
        rate_r <= rd_ns.rate;
        for (int d = 0; d < DELAY_DEPTH - 1; d++) qsh_r[d] <= rd_q[d+1];
        qsh_r[DELAY_DEPTH-1] <= 32'd0;
      end
      S_NC2: begin
        prod_v_r  <= 65'(signed'({1'b0, cfg.mem_gain})) * 65'(diff_r);
        prod_i_r  <= 49'(cur_r) * 49'(signed'({1'b0, cfg.cur_decay}));
        prod_up_r <= 32'(rate_r) * RATE_UP_MUL;
        prod_dn_r <= 32'(rate_r) * RATE_DN_MUL;
      end
      S_NWR: begin
        if (32'(n_r) >= OUT_BASE) begin
          logic [OC_W-1:0] k;
          k = OC_W'(32'(n_r) - OUT_BASE);
          if (k == '0 || nwr_ns.rate > best_rate_r) begin
            best_r      <= k;
            best_rate_r <= nwr_ns.rate;
          end
          if (32'(k) == 0) rate0_r <= nwr_ns.rate;
          if (32'(k) == 1) rate1_r <= nwr_ns.rate;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready)
          out_tdata_r <= {6'd0, rate1_r, rate0_r, best_r[0], mask};
      end
      default: ;
    endcase
  end

endmodule

/* sim/tb.sv */
module tb
  import lsn_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIN = 5;
  localparam int NHID = 10;
  localparam int NOUT = 2;
  localparam int DEPTH = 3;
  localparam int NEUR = NIN + NHID + NOUT;
  localparam int NSYN = NIN * NHID + NHID * NOUT;
  localparam int OBASE = NIN + NHID;

  typedef struct packed {
    logic [15:0] rate1;
    logic [15:0] rate0;
    logic        cls;
    logic [16:0] mask;
  } step_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lif_spiking_network_step dut (.*);

  always #5 clk = ~clk;

  // network copy
  logic [30:0]        p_thr;
  logic signed [31:0] p_rpot;
  logic [30:0]        p_mgain;
  logic [15:0]        p_decay;
  logic [7:0]         p_refr;
  logic [30:0]        p_sgain;
  logic signed [31:0] nv [NEUR];
  logic signed [31:0] ni [NEUR];
  logic [7:0]         nrefr [NEUR];
  logic               nspk [NEUR];
  logic [15:0]        nrate [NEUR];
  logic signed [31:0] dq [NEUR][DEPTH];
  logic signed [31:0] wt [NSYN];

  step_res_t   step_q[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          stall_pct = 0;

  function automatic logic signed [31:0] clip(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // floor division by 2^16 is an arithmetic shift
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> 16;
  endfunction

  task automatic net_reset();
    p_thr = 31'd65536; p_rpot = '0; p_mgain = 31'd655360;
    p_decay = '0; p_refr = 8'd1; p_sgain = 31'd655360;
    for (int n = 0; n < NEUR; n++) begin
      nv[n] = '0; ni[n] = '0; nrefr[n] = '0; nspk[n] = 1'b0; nrate[n] = '0;
      for (int d = 0; d < DEPTH; d++) dq[n][d] = '0;
    end
    for (int s = 0; s < NSYN; s++) wt[s] = '0;
  endtask

  task automatic net_step();
    logic               prev [NEUR];
    logic signed [63:0] v, diff;
    logic [63:0]        r;
    step_res_t          res;
    for (int n = 0; n < NEUR; n++) begin
      prev[n] = nspk[n]; nspk[n] = 1'b0;
      ni[n] = clip(64'(ni[n]) + 64'(dq[n][0]));
      for (int d = 0; d < DEPTH - 1; d++) dq[n][d] = dq[n][d+1];
      dq[n][DEPTH-1] = '0;
    end
    for (int i = 0; i < NIN; i++)
      for (int j = 0; j < NHID; j++)
        if (prev[i])
          dq[NIN+j][QUEUE_SLOT] = clip(64'(dq[NIN+j][QUEUE_SLOT]) + 64'(wt[i*NHID+j]));
    for (int i = 0; i < NHID; i++)
      for (int j = 0; j < NOUT; j++)
        if (prev[NIN+i])
          dq[OBASE+j][QUEUE_SLOT] = clip(64'(dq[OBASE+j][QUEUE_SLOT]) +
                                         64'(wt[NIN*NHID + i*NOUT + j]));
    for (int n = 0; n < NEUR; n++) begin
      if (nrefr[n] > 0) begin
        nrefr[n]--;
        nv[n] = p_rpot;
      end else begin
        v = 64'(nv[n]);
        diff = 64'(ni[n]) - v;
        nv[n] = clip(v + qmul($signed({33'd0, p_mgain}), diff));
        ni[n] = clip(qmul(64'(ni[n]), $signed({48'd0, p_decay})));
        r = 64'(nrate[n]);
        if (64'(nv[n]) >= $signed({33'd0, p_thr})) begin
          nspk[n] = 1'b1; nv[n] = p_rpot; nrefr[n] = p_refr;
          r = (r * 62259 + 64'd214761472 + 32768) >> 16;
          if (r > 65535) r = 64'd65535;
        end else begin
          r = (r * 64881) >> 16;
        end
        nrate[n] = r[15:0];
      end
    end
    res = '0;
    for (int n = 0; n < NEUR && n < MASK_BITS; n++) res.mask[n] = nspk[n];
    res.cls = (nrate[OBASE+1] > nrate[OBASE]);
    res.rate0 = nrate[OBASE];
    res.rate1 = nrate[OBASE+1];
    step_q = {step_q, res};
  endtask

  task automatic net_item(input logic [1:0] kind, input logic [6:0] idx,
                          input logic signed [31:0] val);
    case (kind)
      KIND_WEIGHT: if (idx < NSYN) wt[idx] = val;
      KIND_INPUT:
        if (idx < NIN)
          ni[idx] = clip(64'(ni[idx]) +
                         64'(clip(qmul($signed({33'd0, p_sgain}), 64'(val)))));
      KIND_STEP: net_step();
      default: ;
    endcase
  endtask

  // one transfer on the input stream, with the predictor updated on acceptance;
  // in_tvalid stays high so that the next item can follow at once
  task automatic send_item(input logic [1:0] kind, input logic [6:0] idx,
                           input logic signed [31:0] val);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, val, idx};
    do @(posedge clk); while (!in_tready);
    net_item(kind, idx, val);
    items_sent++;
  endtask

  // bursty sender: a random gap after most bursts
  int burst_left = 0;
  task automatic send_paced(input logic [1:0] kind, input logic [6:0] idx,
                            input logic signed [31:0] val);
    send_item(kind, idx, val);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (step_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] regno, input logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {regno, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (regno)
      REG_THRESHOLD:  p_thr = val[30:0];
      REG_RESET_POT:  p_rpot = val;
      REG_MEM_GAIN:   p_mgain = val[30:0];
      REG_CUR_DECAY:  p_decay = val[15:0];
      REG_REFRACTORY: p_refr = val[7:0];
      REG_STIM_GAIN:  p_sgain = val[30:0];
      default: ;
    endcase
  endtask

  task automatic cfg_setting(input logic [31:0] thr, input logic [31:0] rpot,
                             input logic [31:0] mg, input logic [31:0] dec,
                             input logic [31:0] rf, input logic [31:0] sg);
    drain();
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_RESET_POT, rpot);
    cfg_write(REG_MEM_GAIN, mg);
    cfg_write(REG_CUR_DECAY, dec);
    cfg_write(REG_REFRACTORY, rf);
    cfg_write(REG_STIM_GAIN, sg);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h60000)) - 32'sh18000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_amp();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h8000)) - 32'sh2000;
    endcase
  endfunction

  task automatic load_all_weights();
    for (int s = 0; s < NSYN; s++) send_paced(KIND_WEIGHT, 7'(s), rand_weight());
  endtask

  task automatic test_directed();
    for (int s = 0; s < NSYN; s++)
      send_item(KIND_WEIGHT, 7'(s), (s % 2) ? 32'sh00030000 : 32'sh00018000);
    send_item(KIND_WEIGHT, 7'd0, 32'sh7FFFFFFF);
    send_item(KIND_WEIGHT, 7'd1, 32'sh80000000);
    send_item(KIND_WEIGHT, 7'd127, 32'sh12345678);   // beyond last synapse
    send_item(KIND_WEIGHT, 7'(NSYN), 32'shFFFFFFFF);
    send_item(KIND_INPUT, 7'd0, 32'sh7FFFFFFF);
    send_item(KIND_INPUT, 7'd1, 32'sh80000000);
    send_item(KIND_INPUT, 7'd4, 32'sh00010000);
    send_item(KIND_INPUT, 7'd5, 32'sh00010000);      // channel out of range
    send_item(KIND_INPUT, 7'd127, 32'sh7FFFFFFF);
    send_item(2'd3, 7'd3, 32'sh55555555);            // unused kind
    send_item(2'd3, 7'd124, 32'shAAAAAAAA);
    for (int k = 0; k < 8; k++) begin
      send_item(KIND_INPUT, 7'(k % NIN), 32'sh00008000);
      send_item(KIND_STEP, 7'h7F, 32'shFFFFFFFF);
    end
  endtask

  task automatic test_random(input int count, input int well_pct);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < well_pct) begin
        // stimulate then step, as a network would be driven
        repeat ($urandom_range(0, 4)) begin
          send_paced(KIND_INPUT, 7'($urandom_range(0, NIN - 1)), rand_amp());
          sent++;
        end
        send_paced(KIND_STEP, 7'($urandom), $urandom);
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0: send_paced(KIND_WEIGHT, 7'($urandom), rand_weight());
          1: send_paced(KIND_INPUT, 7'($urandom), $urandom);
          2: send_paced(2'd3, 7'($urandom), $urandom);
          default: send_paced(KIND_STEP, 7'($urandom), $urandom);
        endcase
        sent++;
      end
    end
  endtask

  task automatic test_settings();
    cfg_setting(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF, 32'hFF, 32'h7FFFFFFF);
    test_random(150, 80);
    cfg_setting(32'h0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0);
    test_random(150, 80);
    cfg_setting(32'h00008000, 32'hFFFF0000, 32'h00004000, 32'hC000, 32'h2, 32'h00020000);
    load_all_weights();
    test_random(500, 85);
    cfg_setting(32'h00010000, 32'h0, 32'h000A0000, 32'h8000, 32'h0, 32'h000A0000);
    test_random(500, 85);
    cfg_setting($urandom_range(0, 32'h40000), $urandom, $urandom_range(0, 32'h20000),
                $urandom_range(0, 65535), $urandom_range(0, 5), $urandom_range(0, 32'h40000));
    test_random(300, 85);
  endtask

  // receiver stall pattern; also stretches with no stalls
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_pct <= $urandom_range(0, 2) * 40;
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    step_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[49:0];
      results_seen++;
      if (step_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = step_q.pop_front();
        if (got.mask !== want.mask || got.cls !== want.cls ||
            got.rate0 !== want.rate0 || got.rate1 !== want.rate1) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"step %0d: mask exp %h got %h, class exp %0d got %0d, ",
                      "rate0 exp %h got %h, rate1 exp %h got %h"},
                     results_seen, want.mask, got.mask, want.cls, got.cls,
                     want.rate0, got.rate0, want.rate1, got.rate1);
        end
      end
    end
  end

  initial begin
    net_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200, 80);
    test_settings();
    drain();
    $display("sent %0d items, checked %0d time-step results over six register settings",
             items_sent, results_seen);
    if (mismatches == 0 && step_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, step_q.size());
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
